FILE: sv/pcst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcst_pkg;

  // Class queue geometry.
  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int READING_W = 11;
  localparam int SAMPLE_W  = 10;
  localparam int THR_W     = 10;
  localparam int CLASS_W   = 3;
  localparam int STEPS_W   = 7;
  localparam int TOTAL_W   = 16;

  localparam logic [READING_W-1:0] READING_RESET = 11'd2000;
  localparam logic [STEPS_W-1:0]   QUARTER_STEPS = 7'd50;
  localparam logic [STEPS_W-1:0]   HALF_STEPS    = 7'd100;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_CLEARED = 2'd1;
  localparam logic [1:0] OP_EXIT    = 2'd2;
  localparam logic [1:0] OP_REPORT  = 2'd3;

  // Class codes; also the turntable position codes.
  localparam logic [CLASS_W-1:0] CLS_NONE  = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_BLACK = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_STEEL = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_WHITE = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_ALU   = 3'd4;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_EMPTY = 2'd1;
  localparam logic [1:0] FAULT_FULL  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ALUMINUM_MAX = 2'd0;
  localparam logic [1:0] REG_STEEL_MAX    = 2'd1;
  localparam logic [1:0] REG_WHITE_MAX    = 2'd2;
  localparam logic [1:0] REG_BLACK_MAX    = 2'd3;

  localparam logic [THR_W-1:0] ALUMINUM_MAX_RESET = 10'd100;
  localparam logic [THR_W-1:0] STEEL_MAX_RESET    = 10'd700;
  localparam logic [THR_W-1:0] WHITE_MAX_RESET    = 10'd930;
  localparam logic [THR_W-1:0] BLACK_MAX_RESET    = 10'd1000;

  typedef struct packed {
    logic [THR_W-1:0] aluminum_max;
    logic [THR_W-1:0] steel_max;
    logic [THR_W-1:0] white_max;
    logic [THR_W-1:0] black_max;
  } thresholds_t;

endpackage

`default_nettype wire

FILE: sv/pcst_classify.sv
`timescale 1ns / 1ps
`default_nettype none

// Maps the minimum reading onto a class code; the thresholds are tested in the
// order aluminum, steel, white, black, so the first one that holds wins.
module pcst_classify (
  input  wire logic [pcst_pkg::READING_W-1:0] min_reading,
  input  wire pcst_pkg::thresholds_t          thr,
  output logic [pcst_pkg::CLASS_W-1:0]        part_class
);

  always_comb begin
    if (min_reading <= {1'b0, thr.aluminum_max}) begin
      part_class = pcst_pkg::CLS_ALU;
    end else if (min_reading <= {1'b0, thr.steel_max}) begin
      part_class = pcst_pkg::CLS_STEEL;
    end else if (min_reading <= {1'b0, thr.white_max}) begin
      part_class = pcst_pkg::CLS_WHITE;
    end else if (min_reading <= {1'b0, thr.black_max}) begin
      part_class = pcst_pkg::CLS_BLACK;
    end else begin
      part_class = pcst_pkg::CLS_NONE;
    end
  end

endmodule

`default_nettype wire

FILE: sv/part_classify_sort_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Part classification and sorting tracker. The input stream carries one
// transaction per event (tuser selects sample, part cleared, part at exit or
// report) and every input transaction yields exactly one output transaction
// with the class handled, the planned turntable move, a fault code, the four
// sorted counts, the queue fill and the turntable position after the event.
// Sample, cleared and report transactions can follow one another in
// consecutive cycles; an exit transaction with a non-empty queue holds the
// input off in the exit state, as the head class comes out of the class
// queue memory, which has a registered read port, in the cycle after the
// address is presented. The output register lets the next input transaction
// in while the previous result is taken in the same cycle. Thresholds are to
// be written through the cfg port while the block is idle (not enforced).
module part_classify_sort_tracker_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel. tdata: sample_value [9:0], zero padding [15:10].
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,
  // tuser: opcode [1:0].
  input  wire logic [1:0]  in_tuser,
  // Result channel. tdata: part_class [2:0], turn_cw [3], turn_steps [10:4],
  // fault [12:11], steel_sorted [28:13], aluminum_sorted [44:29],
  // white_sorted [60:45], black_sorted [76:61], on_belt [83:77],
  // bin_position [86:84], zero padding [87].
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,
  // Configuration write port.
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_wdata
);

  localparam int DEPTH = pcst_pkg::QUEUE_DEPTH;
  localparam int PW    = pcst_pkg::PTR_W;
  localparam int CW    = pcst_pkg::CNT_W;
  localparam int KW    = pcst_pkg::CLASS_W;
  localparam int TW    = pcst_pkg::TOTAL_W;

  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXIT
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  pcst_pkg::thresholds_t thr_r;

  // Tracking state. Totals and per-class queue counts are indexed by code-1.
  logic [pcst_pkg::READING_W-1:0] min_reading_r, min_reading_nxt;
  logic [PW-1:0]                  head_r, head_nxt;
  logic [PW-1:0]                  tail_r, tail_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [TW-1:0]                  totals_r [4];
  logic [TW-1:0]                  totals_nxt [4];
  logic [CW-1:0]                  queued_r [4];
  logic [CW-1:0]                  queued_nxt [4];
  logic [KW-1:0]                  position_r, position_nxt;
  logic                           last_cw_r, last_cw_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [87:0] out_data_r, out_data_nxt;

  // Class queue memory.
  logic [KW-1:0] queue_mem [DEPTH];
  logic [KW-1:0] rd_data_r;
  logic          mem_wr_en;
  logic          mem_rd_en;

  logic [1:0]                    op;
  logic [pcst_pkg::SAMPLE_W-1:0] sample;
  logic                          accept;
  logic [KW-1:0]                 new_class;

  // Fields of the result being assembled.
  logic [KW-1:0]                 r_class;
  logic                          r_cw;
  logic [pcst_pkg::STEPS_W-1:0]  r_steps;
  logic [1:0]                    r_fault;
  logic [TW-1:0]                 sorted [4];
  logic signed [3:0]             diff;
  logic                          load;

  assign op     = in_tuser;
  assign sample = in_tdata[pcst_pkg::SAMPLE_W-1:0];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  pcst_classify u_classify (
    .min_reading (min_reading_r),
    .thr         (thr_r),
    .part_class  (new_class)
  );

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + PW'(1);
  endfunction

  assign mem_wr_en = accept && (op == pcst_pkg::OP_CLEARED) && (count_r < FULL_CNT);
  assign mem_rd_en = accept && (op == pcst_pkg::OP_EXIT) && (count_r != '0);

  always_comb begin
    state_nxt       = state_r;
    min_reading_nxt = min_reading_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    position_nxt    = position_r;
    last_cw_nxt     = last_cw_r;
    for (int k = 0; k < 4; k++) begin
      totals_nxt[k] = totals_r[k];
      queued_nxt[k] = queued_r[k];
    end
    r_class = pcst_pkg::CLS_NONE;
    r_cw    = 1'b0;
    r_steps = '0;
    r_fault = pcst_pkg::FAULT_NONE;
    diff    = '0;
    load    = 1'b0;

    if (state_r == S_EXIT) begin
      // Head class is now on the memory read port.
      load      = 1'b1;
      state_nxt = S_IDLE;
      head_nxt  = next_slot(head_r);
      count_nxt = count_r - CW'(1);
      for (int k = 0; k < 4; k++) begin
        if ((rd_data_r == KW'(k + 1)) && (queued_r[k] != '0)) begin
          queued_nxt[k] = queued_r[k] - CW'(1);
        end
      end
      r_class = rd_data_r;
      diff    = $signed({1'b0, rd_data_r}) - $signed({1'b0, position_r});
      if ((diff == 4'sd3) || (diff == -4'sd1)) begin
        r_steps     = pcst_pkg::QUARTER_STEPS;
        r_cw        = 1'b0;
        last_cw_nxt = 1'b0;
      end else if ((diff == -4'sd3) || (diff == 4'sd1)) begin
        r_steps     = pcst_pkg::QUARTER_STEPS;
        r_cw        = 1'b1;
        last_cw_nxt = 1'b1;
      end else if ((diff == 4'sd2) || (diff == -4'sd2)) begin
        r_steps = pcst_pkg::HALF_STEPS;
        r_cw    = last_cw_r;
      end
      position_nxt = rd_data_r;
    end else if (accept) begin
      unique case (op)
        pcst_pkg::OP_SAMPLE: begin
          load = 1'b1;
          if ({1'b0, sample} < min_reading_r) begin
            min_reading_nxt = {1'b0, sample};
          end
        end
        pcst_pkg::OP_CLEARED: begin
          load    = 1'b1;
          r_class = new_class;
          for (int k = 0; k < 4; k++) begin
            if (new_class == KW'(k + 1)) begin
              totals_nxt[k] = totals_r[k] + TW'(1);
            end
          end
          if (count_r >= FULL_CNT) begin
            r_fault = pcst_pkg::FAULT_FULL;
          end else begin
            tail_nxt  = next_slot(tail_r);
            count_nxt = count_r + CW'(1);
            for (int k = 0; k < 4; k++) begin
              if (new_class == KW'(k + 1)) begin
                queued_nxt[k] = queued_r[k] + CW'(1);
              end
            end
          end
          min_reading_nxt = pcst_pkg::READING_RESET;
        end
        pcst_pkg::OP_EXIT: begin
          if (count_r == '0) begin
            load    = 1'b1;
            r_fault = pcst_pkg::FAULT_EMPTY;
          end else begin
            state_nxt = S_EXIT;
          end
        end
        pcst_pkg::OP_REPORT: begin
          load = 1'b1;
        end
        default: begin
          load = 1'b1;
        end
      endcase
    end

    for (int k = 0; k < 4; k++) begin
      sorted[k] = totals_nxt[k] - TW'(queued_nxt[k]);
    end

    out_data_nxt = {1'b0, position_nxt, 7'(count_nxt),
                    sorted[0], sorted[2], sorted[3], sorted[1],
                    r_fault, r_steps, r_cw, r_class};

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      min_reading_r <= pcst_pkg::READING_RESET;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      position_r    <= pcst_pkg::CLS_BLACK;
      last_cw_r     <= 1'b1;
      for (int k = 0; k < 4; k++) begin
        totals_r[k] <= '0;
        queued_r[k] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      min_reading_r <= min_reading_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      count_r       <= count_nxt;
      position_r    <= position_nxt;
      last_cw_r     <= last_cw_nxt;
      for (int k = 0; k < 4; k++) begin
        totals_r[k] <= totals_nxt[k];
        queued_r[k] <= queued_nxt[k];
      end
    end
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.aluminum_max <= pcst_pkg::ALUMINUM_MAX_RESET;
      thr_r.steel_max    <= pcst_pkg::STEEL_MAX_RESET;
      thr_r.white_max    <= pcst_pkg::WHITE_MAX_RESET;
      thr_r.black_max    <= pcst_pkg::BLACK_MAX_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pcst_pkg::REG_ALUMINUM_MAX: thr_r.aluminum_max <= cfg_wdata;
        pcst_pkg::REG_STEEL_MAX:    thr_r.steel_max    <= cfg_wdata;
        pcst_pkg::REG_WHITE_MAX:    thr_r.white_max    <= cfg_wdata;
        pcst_pkg::REG_BLACK_MAX:    thr_r.black_max    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Class queue: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      queue_mem[tail_r] <= new_class;
    end
    if (mem_rd_en) begin
      rd_data_r <= queue_mem[head_r];
    end
  end

endmodule

`default_nettype wire

FILE: sv/pcst_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pcst_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata
);

  // A result waiting to be taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // Only the three planned move lengths ever appear.
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:4] == 7'd0) || (out_tdata[10:4] == 7'd50) ||
                   (out_tdata[10:4] == 7'd100))
    else $error("illegal turn step count");

  // A fault result never plans a move.
  a_fault_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[12:11] != 2'd0) |-> (out_tdata[10:4] == 7'd0))
    else $error("move planned together with a fault");

  // The input is held off while a result is stalled at the output.
  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !(in_tvalid && in_tready))
    else $error("input accepted with the output register blocked");

endmodule

bind part_classify_sort_tracker_unit pcst_checker u_pcst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
